// File: rtl/tmd_pkg.sv
`timescale 1ns / 1ps
package tmd_pkg;

	// operand and result widths
	localparam int AW    = 16;            // attenuation, Q6.10
	localparam int DW    = 16;            // density, Q4.12
	localparam int CFGW  = 48;            // widest configuration register
	localparam int IDXW  = 3;             // configuration register index
	localparam int XW    = AW + 1;        // signed attenuation difference
	localparam int PW    = 2 * DW;        // density pair product
	localparam int XPW   = XW + PW + 1;   // difference times density product
	localparam int MW    = XPW + 1;       // system coefficient, signed
	localparam int MAGW  = 50;            // coefficient magnitude
	localparam int HW    = MAGW / 2;      // half of a magnitude for partial products
	localparam int PRW   = 2 * MAGW;      // product magnitude
	localparam int SW    = 104;           // signed determinant and numerators
	localparam int NMW   = SW - 1;        // divider operand magnitude
	localparam int RW    = NMW + 1;       // divider remainder
	localparam int FBW   = 2 * AW + 1;    // fallback numerator and denominator
	localparam int FRAC  = 16;            // fraction bits of a weight
	localparam int QW    = 32;            // quotient bits
	localparam int WW    = 32;            // weight width
	localparam int NPROD = 6;             // wide products per pixel
	localparam int NCOEF = 6;             // coefficients per pixel
	localparam int NLANE = 3;             // divider lanes
	localparam int DIV_LAT = QW + 2;      // divider lane latency
	localparam int FRONT_N = 10;          // stages ahead of the divider lanes
	localparam int PIPE_N  = FRONT_N + DIV_LAT;

	localparam logic [CFGW-1:0] DENS_RESET = 48'h1000_1000_1000;
	localparam logic signed [WW-1:0] WMAX = 32'sh7FFF_FFFF;
	localparam logic signed [WW-1:0] WMIN = 32'sh8000_0000;
	localparam logic [QW-1:0] NEG_LIMIT   = 32'h8000_0000;

	// coefficient order: m00, m01, m10, m11, b0, b1
	localparam int C_M00 = 0;
	localparam int C_M01 = 1;
	localparam int C_M10 = 2;
	localparam int C_M11 = 3;
	localparam int C_B0  = 4;
	localparam int C_B1  = 5;

	// operand pairs of the wide products:
	// m00*m11, m01*m10, b0*m11, m01*b1, m00*b1, b0*m10
	localparam int PROD_A [NPROD] = '{C_M00, C_M01, C_B0, C_M01, C_M00, C_B0};
	localparam int PROD_B [NPROD] = '{C_M11, C_M10, C_M11, C_B1, C_B1, C_M10};

	typedef enum logic [IDXW-1:0] {
		REG_E1_M1   = 3'd0,
		REG_E2_M1   = 3'd1,
		REG_E1_M2   = 3'd2,
		REG_E2_M2   = 3'd3,
		REG_E1_M3   = 3'd4,
		REG_E2_M3   = 3'd5,
		REG_DENS    = 3'd6,
		REG_SPECIAL = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_SOLVED = 2'd1,
		ST_RATIO  = 2'd2,
		ST_DIVZ   = 2'd3
	} status_t;

	typedef struct packed {
		logic    valid;
		status_t st;
	} ctl_t;

endpackage

// File: rtl/tmd_div_lane.sv
`timescale 1ns / 1ps
module tmd_div_lane import tmd_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NMW-1:0]       num,
	input  logic [NMW-1:0]       den,
	input  logic                 neg,
	output logic signed [WW-1:0] weight
);

	logic [RW-1:0]  rem_s [0:QW];
	logic [QW-1:0]  low_s [0:QW];
	logic [QW-1:0]  quo_s [0:QW];
	logic [NMW-1:0] den_s [0:QW];
	logic           neg_s [0:QW];
	logic           ovf_s [0:QW];
	logic [NMW-1:0] num_hi;
	logic [QW-1:0]  qv;

	assign num_hi = num >> FRAC;

	// entry: quotient would need more than QW bits when num_hi >= den
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, num_hi};
			low_s[0] <= {num[FRAC-1:0], {(QW-FRAC){1'b0}}};
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			ovf_s[0] <= (num_hi >= den);
		end
	end

	// one restoring step per stage
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW-1:0] trial;
		logic [RW:0]   diff;
		assign trial = {rem_s[i][RW-2:0], low_s[i][QW-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= diff[RW] ? trial : diff[RW-1:0];
				quo_s[i+1] <= {quo_s[i][QW-2:0], ~diff[RW]};
				low_s[i+1] <= {low_s[i][QW-2:0], 1'b0};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign qv = quo_s[QW];

	// sign and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QW]) begin
				if (ovf_s[QW] || qv > NEG_LIMIT) begin
					weight <= WMIN;
				end else begin
					weight <= -$signed(qv);
				end
			end else begin
				if (ovf_s[QW] || qv[QW-1]) begin
					weight <= WMAX;
				end else begin
					weight <= $signed(qv);
				end
			end
		end
	end

endmodule

// File: rtl/three_material_decomposition_unit.sv
`timescale 1ns / 1ps
// Three-material decomposition of dual-energy CT pixels. Each input transaction
// carries the attenuations at two energies (unsigned Q6.10) and a mask bit; each
// output transaction carries three signed Q16.16 weights and a status (0 not
// masked, 1 solved, 2 ratio to material one, 3 division by zero). The block
// takes one pixel per clock while the output side does not stall and returns
// results in input order: ten stages build the 2x2 system, the determinant and
// the numerators exactly (wide products are cut into 25x25 partial products),
// then three divider lanes of 34 stages each (an entry stage, 32 stages that
// retire one quotient bit apiece and a sign and saturation stage), and an output
// register follows. A stall on the output while a result waits there holds the
// whole pipeline in place. The material table, densities and special mode are
// written by the user through the wr_* port only while idle; the block does not enforce it.
module three_material_decomposition_unit import tmd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 wr_en,
	input  logic [IDXW-1:0]      wr_index,
	input  logic [CFGW-1:0]      wr_data,
	// pixel input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [AW-1:0]        atten_e1,
	input  logic [AW-1:0]        atten_e2,
	input  logic                 in_mask,
	// weights output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [WW-1:0] weight_one,
	output logic signed [WW-1:0] weight_two,
	output logic signed [WW-1:0] weight_three,
	output logic [1:0]           status
);

	// configuration registers
	logic [AW-1:0]   t1a_q, t1b_q, t2a_q, t2b_q, t3a_q, t3b_q;
	logic [CFGW-1:0] dens_q;
	logic            special_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1a_q     <= '0;
			t1b_q     <= '0;
			t2a_q     <= '0;
			t2b_q     <= '0;
			t3a_q     <= '0;
			t3b_q     <= '0;
			dens_q    <= DENS_RESET;
			special_q <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_E1_M1:   t1a_q     <= wr_data[AW-1:0];
				REG_E2_M1:   t1b_q     <= wr_data[AW-1:0];
				REG_E1_M2:   t2a_q     <= wr_data[AW-1:0];
				REG_E2_M2:   t2b_q     <= wr_data[AW-1:0];
				REG_E1_M3:   t3a_q     <= wr_data[AW-1:0];
				REG_E2_M3:   t3b_q     <= wr_data[AW-1:0];
				REG_DENS:    dens_q    <= wr_data;
				REG_SPECIAL: special_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// the whole pipeline moves when the output register is free
	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// pipeline control: valid bit and status per stage
	ctl_t ctl_s [1:PIPE_N];
	ctl_t ctl_in;
	ctl_t ctl_s9_c;

	logic [DW-1:0] d1, d2, d3;
	logic          below;

	assign d1 = dens_q[DW-1:0];
	assign d2 = dens_q[2*DW-1:DW];
	assign d3 = dens_q[3*DW-1:2*DW];
	assign below = (atten_e1 < t1a_q) || (atten_e2 < t1b_q);

	// provisional status, refined once the determinant is known
	always_comb begin
		ctl_in.valid = in_valid;
		if (!in_mask) begin
			ctl_in.st = ST_NONE;
		end else if (special_q && below) begin
			ctl_in.st = (t1a_q == '0 || t1b_q == '0) ? ST_DIVZ : ST_RATIO;
		end else begin
			ctl_in.st = (d1 == '0 || d2 == '0 || d3 == '0) ? ST_DIVZ : ST_SOLVED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PIPE_N; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (adv) begin
			ctl_s[1] <= ctl_in;
			for (int k = 2; k <= PIPE_N; k++) begin
				if (k == 9) begin
					ctl_s[k] <= ctl_s9_c;
				end else begin
					ctl_s[k] <= ctl_s[k-1];
				end
			end
		end
	end

	// s1: attenuation differences, density products, fallback products
	logic signed [XW-1:0] x1a_s1, x2a_s1, x3a_s1, x1b_s1, x2b_s1, x3b_s1;
	logic [PW-1:0]        p1_s1, p2_s1, p3_s1;
	logic [2*AW-1:0]      fa_s1, fb_s1, fc_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x1a_s1 <= $signed({1'b0, atten_e1}) - $signed({1'b0, t1a_q});
			x2a_s1 <= $signed({1'b0, atten_e1}) - $signed({1'b0, t2a_q});
			x3a_s1 <= $signed({1'b0, atten_e1}) - $signed({1'b0, t3a_q});
			x1b_s1 <= $signed({1'b0, atten_e2}) - $signed({1'b0, t1b_q});
			x2b_s1 <= $signed({1'b0, atten_e2}) - $signed({1'b0, t2b_q});
			x3b_s1 <= $signed({1'b0, atten_e2}) - $signed({1'b0, t3b_q});
			p1_s1  <= d2 * d3;
			p2_s1  <= d1 * d3;
			p3_s1  <= d1 * d2;
			fa_s1  <= atten_e1 * t1b_q;
			fb_s1  <= atten_e2 * t1a_q;
			fc_s1  <= t1a_q * t1b_q;
		end
	end

	// s2: differences scaled by density products; fallback ratio operands
	logic signed [XPW-1:0] xp1a_s2, xp2a_s2, xp3a_s2, xp1b_s2, xp2b_s2, xp3b_s2;
	logic [FBW-1:0]        fbn_s [2:9];
	logic [FBW-1:0]        fbd_s [2:9];

	always_ff @(posedge clk) begin
		if (adv) begin
			xp1a_s2 <= x1a_s1 * $signed({1'b0, p1_s1});
			xp2a_s2 <= x2a_s1 * $signed({1'b0, p2_s1});
			xp3a_s2 <= x3a_s1 * $signed({1'b0, p3_s1});
			xp1b_s2 <= x1b_s1 * $signed({1'b0, p1_s1});
			xp2b_s2 <= x2b_s1 * $signed({1'b0, p2_s1});
			xp3b_s2 <= x3b_s1 * $signed({1'b0, p3_s1});
			fbn_s[2] <= {1'b0, fa_s1} + {1'b0, fb_s1};
			fbd_s[2] <= {fc_s1, 1'b0};
			for (int k = 3; k <= 9; k++) begin
				fbn_s[k] <= fbn_s[k-1];
				fbd_s[k] <= fbd_s[k-1];
			end
		end
	end

	// s3: system coefficients
	logic signed [MW-1:0] mv_s3 [NCOEF];

	always_ff @(posedge clk) begin
		if (adv) begin
			mv_s3[C_M00] <= xp1a_s2 - xp3a_s2;
			mv_s3[C_M01] <= xp2a_s2 - xp3a_s2;
			mv_s3[C_M10] <= xp1b_s2 - xp3b_s2;
			mv_s3[C_M11] <= xp2b_s2 - xp3b_s2;
			mv_s3[C_B0]  <= -xp3a_s2;
			mv_s3[C_B1]  <= -xp3b_s2;
		end
	end

	// s4: magnitudes and signs
	logic [MAGW-1:0] mag_s4 [NCOEF];
	logic            sgn_s4 [NCOEF];
	logic            m00z_s [4:8];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NCOEF; c++) begin
				mag_s4[c] <= MAGW'(mv_s3[c][MW-1] ? -mv_s3[c] : mv_s3[c]);
				sgn_s4[c] <= mv_s3[c][MW-1];
			end
			m00z_s[4] <= (mv_s3[C_M00] == '0);
			for (int k = 5; k <= 8; k++) begin
				m00z_s[k] <= m00z_s[k-1];
			end
		end
	end

	// s5..s7: wide products from four partial products each
	logic [PRW/2-1:0]     ll_s5 [NPROD];
	logic [PRW/2-1:0]     lh_s5 [NPROD];
	logic [PRW/2-1:0]     hl_s5 [NPROD];
	logic [PRW/2-1:0]     hh_s5 [NPROD];
	logic                 psg_s5 [NPROD];
	logic [PRW-1:0]       pm_s6 [NPROD];
	logic                 psg_s6 [NPROD];
	logic signed [SW-1:0] ps_s7 [NPROD];

	for (genvar k = 0; k < NPROD; k++) begin : g_prod
		logic [MAGW-1:0]      opa, opb;
		logic signed [SW-1:0] pext;
		assign opa  = mag_s4[PROD_A[k]];
		assign opb  = mag_s4[PROD_B[k]];
		assign pext = $signed({{(SW-PRW){1'b0}}, pm_s6[k]});
		always_ff @(posedge clk) begin
			if (adv) begin
				ll_s5[k]  <= opa[HW-1:0]    * opb[HW-1:0];
				lh_s5[k]  <= opa[HW-1:0]    * opb[MAGW-1:HW];
				hl_s5[k]  <= opa[MAGW-1:HW] * opb[HW-1:0];
				hh_s5[k]  <= opa[MAGW-1:HW] * opb[MAGW-1:HW];
				psg_s5[k] <= sgn_s4[PROD_A[k]] ^ sgn_s4[PROD_B[k]];
				pm_s6[k]  <= PRW'(ll_s5[k])
					+ ((PRW'(lh_s5[k]) + PRW'(hl_s5[k])) << HW)
					+ (PRW'(hh_s5[k]) << (2 * HW));
				psg_s6[k] <= psg_s5[k];
				ps_s7[k]  <= psg_s6[k] ? -pext : pext;
			end
		end
	end

	// s8: determinant and first two numerators
	logic signed [SW-1:0] det_s8, n0_s8, n1_s8;
	// s9: third numerator
	logic signed [SW-1:0] det_s9, n0_s9, n1_s9, n2_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s8 <= ps_s7[0] - ps_s7[1];
			n0_s8  <= ps_s7[2] - ps_s7[3];
			n1_s8  <= ps_s7[4] - ps_s7[5];
			det_s9 <= det_s8;
			n0_s9  <= n0_s8;
			n1_s9  <= n1_s8;
			n2_s9  <= det_s8 - n0_s8 - n1_s8;
		end
	end

	// a singular system or a zero pivot ends in the division-by-zero status
	always_comb begin
		ctl_s9_c = ctl_s[8];
		if (ctl_s[8].st == ST_SOLVED && (m00z_s[8] || det_s8 == '0)) begin
			ctl_s9_c.st = ST_DIVZ;
		end
	end

	// s10: divider operands; lane one takes the fallback ratio when selected
	logic [NMW-1:0] num_s10 [NLANE];
	logic [NMW-1:0] den_s10 [NLANE];
	logic           neg_s10 [NLANE];
	logic [NMW-1:0] det_mag, n0_mag, n1_mag, n2_mag;

	assign det_mag = NMW'(det_s9[SW-1] ? -det_s9 : det_s9);
	assign n0_mag  = NMW'(n0_s9[SW-1] ? -n0_s9 : n0_s9);
	assign n1_mag  = NMW'(n1_s9[SW-1] ? -n1_s9 : n1_s9);
	assign n2_mag  = NMW'(n2_s9[SW-1] ? -n2_s9 : n2_s9);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_s[9].st == ST_RATIO) begin
				num_s10[0] <= NMW'(fbn_s[9]);
				den_s10[0] <= NMW'(fbd_s[9]);
				neg_s10[0] <= 1'b0;
			end else begin
				num_s10[0] <= n0_mag;
				den_s10[0] <= det_mag;
				neg_s10[0] <= n0_s9[SW-1] ^ det_s9[SW-1];
			end
			num_s10[1] <= n1_mag;
			den_s10[1] <= det_mag;
			neg_s10[1] <= n1_s9[SW-1] ^ det_s9[SW-1];
			num_s10[2] <= n2_mag;
			den_s10[2] <= det_mag;
			neg_s10[2] <= n2_s9[SW-1] ^ det_s9[SW-1];
		end
	end

	// three quotient lanes, truncated and saturated to Q16.16
	logic signed [WW-1:0] lane_w [NLANE];

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		tmd_div_lane u_lane (
			.clk    (clk),
			.en     (adv),
			.num    (num_s10[l]),
			.den    (den_s10[l]),
			.neg    (neg_s10[l]),
			.weight (lane_w[l])
		);
	end

	// output register
	status_t              status_q;
	logic signed [WW-1:0] w1_q, w2_q, w3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_s[PIPE_N].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= ctl_s[PIPE_N].st;
			case (ctl_s[PIPE_N].st)
				ST_SOLVED: begin
					w1_q <= lane_w[0];
					w2_q <= lane_w[1];
					w3_q <= lane_w[2];
				end
				ST_RATIO: begin
					w1_q <= lane_w[0];
					w2_q <= '0;
					w3_q <= '0;
				end
				default: begin
					w1_q <= '0;
					w2_q <= '0;
					w3_q <= '0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign weight_one   = w1_q;
	assign weight_two   = w2_q;
	assign weight_three = w3_q;

`ifndef SYNTHESIS
	// an accepted pixel lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ctl_s[1].valid)
		else $error("accepted pixel missing from first stage");

	// unmasked pixels and division by zero give zero weights
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_NONE || status == ST_DIVZ)) |->
		(weight_one == '0 && weight_two == '0 && weight_three == '0))
		else $error("nonzero weight without a solution");

	// the ratio fallback fills weight one only and never goes negative
	a_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_RATIO) |->
		(weight_two == '0 && weight_three == '0 && !weight_one[WW-1]))
		else $error("bad fallback ratio result");

	// a stalled result holds its status while the pipeline is frozen
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(ctl_s[PIPE_N]) && $stable(status)))
		else $error("pipeline moved during a stall");
`endif

endmodule
